@@ rtl/dq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned OCC_W = 5;

	typedef enum logic [1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_BACK  = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_BACK   = 2'd3
	} dq_op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_OVER  = 2'd2
	} dq_status_t;

	localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

	typedef logic signed [WORD_W-1:0] dq_word_t;

	// One-hot command broadcast to every cell; all zero means hold.
	typedef struct packed {
		logic add_head;
		logic add_tail;
		logic take_head;
		logic take_tail;
	} dq_cmd_t;

	// What one cell shows its neighbors: occupancy and the words of the
	// front-aligned and back-aligned chains.
	typedef struct packed {
		logic     valid;
		dq_word_t front_word;
		dq_word_t back_word;
	} dq_link_t;

endpackage

`default_nettype wire

@@ rtl/dq_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface dq_req_if;
	logic            valid;
	logic            ready;
	dq_pkg::dq_op_t  op;
	dq_pkg::dq_word_t value;

	modport source (output valid, output op, output value, input ready);
	modport sink (input valid, input op, input value, output ready);
endinterface

`default_nettype wire

@@ rtl/dq_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface dq_rsp_if;
	logic                           valid;
	logic                           ready;
	dq_pkg::dq_word_t               popped_value;
	dq_pkg::dq_word_t               front_value;
	dq_pkg::dq_word_t               back_value;
	logic [1:0]                     status;
	logic [dq_pkg::OCC_W-1:0]       occupancy;

	modport source (output valid, output popped_value, output front_value,
		output back_value, output status, output occupancy, input ready);
	modport sink (input valid, input popped_value, input front_value,
		input back_value, input status, input occupancy, output ready);
endinterface

`default_nettype wire

@@ rtl/double_ended_queue.sv @@
// An accepted request waits in pend_q and its result is offered from the output
// registers; no new request is taken while one is pending. The cell row updates
// at the accepting edge, and the front and back words of cell 0 are registered
// with the result. A result waiting on the output holds off the next request.
// Reset clears the occupancy bits of all cells, the count and the output
// valid; the stored words are not reset and are never read until written.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue #(
	parameter int unsigned DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	dq_req_if.sink     req,
	dq_rsp_if.source   rsp
);
	import dq_pkg::*;

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	dq_link_t link [DEPTH];
	dq_link_t head_left;
	dq_link_t tail_right;

	logic             accept;
	logic             empty;
	logic             full;
	dq_cmd_t          cmd;
	dq_status_t       status_d;
	dq_word_t         popped_d;

	logic             pend_q;
	dq_word_t         popped_q;
	dq_status_t       status_q;
	logic [CNT_W-1:0] count_q;

	logic             out_valid_q;
	dq_word_t         out_popped_q;
	dq_word_t         out_front_q;
	dq_word_t         out_back_q;
	dq_status_t       out_status_q;
	logic [CNT_W-1:0] out_count_q;
	logic             out_free;

	assign out_free = !out_valid_q || rsp.ready;
	assign req.ready = !pend_q && out_free;
	assign accept = req.valid && req.ready;

	assign empty = !link[0].valid;
	assign full = link[DEPTH-1].valid;

	always_comb begin
		cmd = '0;
		status_d = ST_OK;
		popped_d = '0;
		case (req.op)
			OP_PUSH_FRONT: begin
				if (full) status_d = ST_OVER;
				else cmd.add_head = accept;
			end
			OP_PUSH_BACK: begin
				if (full) status_d = ST_OVER;
				else cmd.add_tail = accept;
			end
			OP_POP_FRONT: begin
				if (empty) begin
					status_d = ST_UNDER;
				end else begin
					cmd.take_head = accept;
					popped_d = link[0].front_word;
				end
			end
			OP_POP_BACK: begin
				if (empty) begin
					status_d = ST_UNDER;
				end else begin
					cmd.take_tail = accept;
					popped_d = link[0].back_word;
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	// The request word enters cell 0 from the left as an always occupied
	// neighbor; past the last cell there is only empty space.
	assign head_left = '{valid: 1'b1, front_word: req.value, back_word: req.value};
	assign tail_right = '{valid: 1'b0, front_word: '0, back_word: '0};

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		dq_link_t left_i;
		dq_link_t right_i;

		if (i == 0) begin : g_first
			assign left_i = head_left;
		end else begin : g_mid_left
			assign left_i = link[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_i = tail_right;
		end else begin : g_mid_right
			assign right_i = link[i+1];
		end

		dq_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.value  (req.value),
			.left   (left_i),
			.right  (right_i),
			.state  (link[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (accept) begin
				pend_q <= 1'b1;
			end else if (pend_q && out_free) begin
				pend_q <= 1'b0;
			end
			if (cmd.add_head || cmd.add_tail) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.take_head || cmd.take_tail) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			popped_q <= popped_d;
			status_q <= status_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pend_q && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_q && out_free) begin
			out_popped_q <= popped_q;
			out_status_q <= status_q;
			out_count_q <= count_q;
			out_front_q <= empty ? EMPTY_WORD : link[0].front_word;
			out_back_q <= empty ? EMPTY_WORD : link[0].back_word;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.popped_value = out_popped_q;
	assign rsp.front_value = out_front_q;
	assign rsp.back_value = out_back_q;
	assign rsp.status = out_status_q;
	assign rsp.occupancy = OCC_W'(out_count_q);

endmodule

`default_nettype wire

@@ rtl/dq_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dq_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  dq_pkg::dq_cmd_t  cmd,
	input  dq_pkg::dq_word_t value,
	input  dq_pkg::dq_link_t left,
	input  dq_pkg::dq_link_t right,
	output dq_pkg::dq_link_t state
);
	import dq_pkg::*;

	logic     valid_q;
	dq_word_t front_q;
	dq_word_t back_q;
	logic     first_free;

	// This cell is the first empty slot when it is empty and its left neighbor is occupied.
	assign first_free = left.valid && !valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.add_head || cmd.add_tail) begin
			valid_q <= left.valid;
		end else if (cmd.take_head || cmd.take_tail) begin
			valid_q <= right.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.add_head) begin
			front_q <= left.front_word;
			if (first_free) begin
				back_q <= value;
			end
		end else if (cmd.add_tail) begin
			back_q <= left.back_word;
			if (first_free) begin
				front_q <= value;
			end
		end else if (cmd.take_head) begin
			front_q <= right.front_word;
		end else if (cmd.take_tail) begin
			back_q <= right.back_word;
		end
	end

	assign state = '{valid: valid_q, front_word: front_q, back_word: back_q};

endmodule

`default_nettype wire

@@ sim/tb_double_ended_queue.sv @@
`timescale 1ns / 1ps

module tb_double_ended_queue;
	import dq_pkg::*;

	localparam int unsigned DEPTH = 16;
	localparam int unsigned RANDOM_REQUESTS = 1700;
	localparam int unsigned CYCLE_LIMIT = 200000;

	typedef struct packed {
		dq_word_t popped;
		dq_word_t front;
		dq_word_t back;
		dq_status_t status;
		logic [OCC_W-1:0] occ;
	} deque_result_t;

	typedef struct packed {
		dq_op_t op;
		dq_word_t value;
		logic [7:0] reps;
		logic typed;
		deque_result_t result;
	} directed_row_t;

	localparam dq_word_t MAX_WORD = 32'sh7FFF_FFFF;
	localparam dq_word_t MIN_WORD = 32'sh8000_0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	dq_req_if req();
	dq_rsp_if rsp();

	double_ended_queue #(.DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	always #2 clk = ~clk;

	dq_word_t model_words [DEPTH];
	logic [3:0] model_head = '0;
	logic [3:0] model_tail = '0;
	logic [OCC_W-1:0] model_count = '0;

	deque_result_t pending_results [$];

	int unsigned mismatches = 0;
	int unsigned stray_results = 0;
	int unsigned results_seen = 0;
	int unsigned requests_sent = 0;
	int unsigned overflow_hits = 0;
	int unsigned underflow_hits = 0;
	int unsigned wrap_pushes = 0;
	int unsigned cycles = 0;
	bit steady = 1'b0;

	directed_row_t directed_rows [14] = '{
		'{OP_POP_FRONT, 32'sd0, 8'd1, 1'b1, '{32'sd0, EMPTY_WORD, EMPTY_WORD, ST_UNDER, 5'd0}},
		'{OP_POP_BACK, 32'sd0, 8'd1, 1'b1, '{32'sd0, EMPTY_WORD, EMPTY_WORD, ST_UNDER, 5'd0}},
		'{OP_PUSH_FRONT, MAX_WORD, 8'd1, 1'b1, '{32'sd0, MAX_WORD, MAX_WORD, ST_OK, 5'd1}},
		'{OP_POP_BACK, 32'sd0, 8'd1, 1'b1, '{MAX_WORD, EMPTY_WORD, EMPTY_WORD, ST_OK, 5'd0}},
		'{OP_PUSH_BACK, MIN_WORD, 8'd1, 1'b1, '{32'sd0, MIN_WORD, MIN_WORD, ST_OK, 5'd1}},
		'{OP_POP_FRONT, 32'sd0, 8'd1, 1'b1, '{MIN_WORD, EMPTY_WORD, EMPTY_WORD, ST_OK, 5'd0}},
		'{OP_PUSH_FRONT, -32'sd1, 8'd1, 1'b0, '0},
		'{OP_PUSH_BACK, 32'sd0, 8'd1, 1'b0, '0},
		'{OP_POP_FRONT, 32'sh5555_5555, 8'd1, 1'b0, '0},
		'{OP_POP_BACK, 32'shAAAA_AAAA, 8'd1, 1'b0, '0},
		'{OP_PUSH_BACK, 32'sd1, 8'd16, 1'b0, '0},
		'{OP_PUSH_FRONT, 32'sd2, 8'd1, 1'b1, '{32'sd0, 32'sd1, 32'sd1, ST_OVER, 5'd16}},
		'{OP_PUSH_BACK, 32'sd3, 8'd1, 1'b1, '{32'sd0, 32'sd1, 32'sd1, ST_OVER, 5'd16}},
		'{OP_POP_FRONT, 32'sd0, 8'd1, 1'b0, '0}
	};

	function automatic deque_result_t deque_apply(input dq_op_t op, input dq_word_t value);
		deque_result_t r;
		logic [3:0] last;
		r = '{32'sd0, EMPTY_WORD, EMPTY_WORD, ST_OK, '0};
		case (op)
			OP_PUSH_FRONT: begin
				if (model_count == DEPTH) begin
					r.status = ST_OVER;
				end else begin
					if (model_head == 4'd0)
						wrap_pushes++;
					model_head = model_head - 4'd1;
					model_words[model_head] = value;
					model_count = model_count + 5'd1;
				end
			end
			OP_PUSH_BACK: begin
				if (model_count == DEPTH) begin
					r.status = ST_OVER;
				end else begin
					if (model_tail == 4'd15)
						wrap_pushes++;
					model_words[model_tail] = value;
					model_tail = model_tail + 4'd1;
					model_count = model_count + 5'd1;
				end
			end
			OP_POP_FRONT: begin
				if (model_count == 0) begin
					r.status = ST_UNDER;
				end else begin
					r.popped = model_words[model_head];
					model_head = model_head + 4'd1;
					model_count = model_count - 5'd1;
				end
			end
			default: begin
				if (model_count == 0) begin
					r.status = ST_UNDER;
				end else begin
					model_tail = model_tail - 4'd1;
					r.popped = model_words[model_tail];
					model_count = model_count - 5'd1;
				end
			end
		endcase
		if (model_count != 0) begin
			last = model_tail - 4'd1;
			r.front = model_words[model_head];
			r.back = model_words[last];
		end
		r.occ = model_count;
		if (r.status == ST_OVER)
			overflow_hits++;
		if (r.status == ST_UNDER)
			underflow_hits++;
		return r;
	endfunction

	task automatic send_request(input dq_op_t op, input dq_word_t value, input logic typed,
			input deque_result_t typed_result);
		deque_result_t predicted;
		while (!steady && $urandom_range(99) < 10) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid <= 1'b1;
		req.op <= op;
		req.value <= value;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		predicted = deque_apply(op, value);
		pending_results = {pending_results, (typed ? typed_result : predicted)};
		requests_sent++;
		@(negedge clk);
	endtask

	task automatic check_field(input string name, input logic [31:0] expected,
			input logic [31:0] actual);
		if (expected !== actual) begin
			mismatches++;
			if (mismatches <= 10)
				$display("Mismatch on %s at result %0d: expected %h, got %h.",
					name, results_seen, expected, actual);
		end
	endtask

	always @(negedge clk) begin
		rsp.ready <= steady ? 1'b1 : ($urandom_range(99) >= 10);
	end

	always @(posedge clk) begin
		deque_result_t exp_r;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_results.size() == 0) begin
				stray_results++;
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result with occupancy %0d.", rsp.occupancy);
			end else begin
				exp_r = pending_results[0];
				pending_results.delete(0);
				check_field("popped_value", exp_r.popped, rsp.popped_value);
				check_field("front_value", exp_r.front, rsp.front_value);
				check_field("back_value", exp_r.back, rsp.back_value);
				check_field("status", 32'(exp_r.status), 32'(rsp.status));
				check_field("occupancy", 32'(exp_r.occ), 32'(rsp.occupancy));
			end
			results_seen++;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding.",
				cycles, pending_results.size());
			$display("double_ended_queue verification failed");
			$finish;
		end
	end

	initial begin
		dq_op_t op;
		dq_word_t value;
		int unsigned push_pct;
		req.valid = 1'b0;
		req.op = OP_PUSH_FRONT;
		req.value = '0;
		for (int i = 0; i < DEPTH; i++)
			model_words[i] = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			for (int n = 0; n < directed_rows[i].reps; n++)
				send_request(directed_rows[i].op, directed_rows[i].value,
					directed_rows[i].typed, directed_rows[i].result);
		end

		// Bursts of 32 requests lean toward pushes, toward pops or neither, so the queue swings between empty and full.
		push_pct = 50;
		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			steady = (i >= 600 && i < 1000);
			if (i % 32 == 0)
				case ($urandom_range(2))
					0: push_pct = 20;
					1: push_pct = 50;
					default: push_pct = 80;
				endcase
			if ($urandom_range(99) < push_pct)
				op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
			else
				op = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
			case ($urandom_range(11))
				0: value = MAX_WORD;
				1: value = MIN_WORD;
				2: value = -32'sd1;
				3: value = 32'sd0;
				default: value = $urandom();
			endcase
			send_request(op, value, 1'b0, '0);
		end
		steady = 1'b0;
		req.valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (pending_results.size() != 0 || stray_results != 0)
			mismatches++;

		$display("Sent %0d requests and checked %0d results in %0d cycles.",
			requests_sent, results_seen, cycles);
		$display("Saw %0d overflows, %0d underflows and %0d pushes across the ring wrap.",
			overflow_hits, underflow_hits, wrap_pushes);
		if (mismatches == 0) begin
			$display("double_ended_queue verification clean");
		end else begin
			$display("%0d mismatches in total.", mismatches);
			$display("double_ended_queue verification failed");
		end
		$finish;
	end

endmodule
